>>> hw/rtl/rssfl_pkg.sv
`timescale 1ns / 1ps

package rssfl_pkg;

    // Operation codes carried in the input tuser
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_DEL    = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_SCAN   = 3'd3;
    localparam logic [2:0] OP_SETCUR = 3'd4;

    // Status codes carried in the output tuser
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_DELETED = 3'd2;
    localparam logic [2:0] ST_END     = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // Fixed field widths of the stream payload
    localparam int IDX_FIELD_W  = 11;
    localparam int DATA_FIELD_W = 64;
    localparam int OUT_TDATA_W  = 88;

    // One finished result on its way to the output register
    typedef struct packed {
        logic [2:0]              status;
        logic [IDX_FIELD_W-1:0]  res_idx;
        logic [DATA_FIELD_W-1:0] res_data;
        logic [IDX_FIELD_W-1:0]  slots_used;
    } t_result;

endpackage

>>> hw/rtl/rssfl_out_stage.sv
`timescale 1ns / 1ps

module rssfl_out_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  rssfl_pkg::t_result                  i_result,
    output logic                                o_free,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    // result_index [10:0], result_data [74:11], slots_used [85:75], zero fill above
    output logic [rssfl_pkg::OUT_TDATA_W-1:0]   o_tdata,
    // status [2:0]
    output logic [2:0]                          o_tuser
);

    logic               r_valid;
    rssfl_pkg::t_result r_res;

    // Room for a new result when empty or when the current one leaves now
    assign o_free = !r_valid || i_tready;

    // Hold the result until the receiver takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {2'b00, r_res.slots_used, r_res.res_data, r_res.res_idx};
    assign o_tuser  = r_res.status;

endmodule

>>> hw/rtl/record_slot_store_free_list.sv
`timescale 1ns / 1ps

// Record slot store with a free list of deleted slots.
// Input stream (s_axis): tuser carries the operation (add, delete, read,
// scan next, set cursor); tdata carries the slot index and the record.
// Output stream (m_axis): one transaction per input transaction, with the
// status in tuser and the slot index, record and high-water mark in tdata.
// A single sequencer walks each transaction through issue, evaluate (when a
// slot must be read) and done steps around one slot memory with one read
// and one write port and a registered read. s_axis_tready is high only
// while the sequencer idles. Set cursor, a range fault, a full store, an
// add at the high-water mark or a scan with no slot left skip evaluate;
// delete, read, an add that reuses a free slot, or a scan pass through it.
// A scan walks one slot per cycle in evaluate until a live slot or the end.
// The next transaction is accepted the cycle after the result is loaded.
// Reset empties the store (high-water mark zero, free list empty, cursor
// before the first slot); slot contents need no clearing pass.
// A stalled receiver holds the result in the output register; a second
// result waits in the sequencer until that register frees.

module record_slot_store_free_list #(
    parameter int SLOT_COUNT  = 1024,
    parameter int RECORD_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // slot_index [10:0], record_data [74:11], zero fill above
    input  logic [79:0]                       s_axis_tdata,
    // operation [2:0]
    input  logic [2:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // result_index [10:0], result_data [74:11], slots_used [85:75], zero fill above
    output logic [rssfl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status [2:0]
    output logic [2:0]                        m_axis_tuser
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int HW_W  = $clog2(SLOT_COUNT + 1);
    localparam int CUR_W = (HW_W > rssfl_pkg::IDX_FIELD_W) ? HW_W : rssfl_pkg::IDX_FIELD_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_EVAL  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [2:0]             r_op;
    logic [10:0]            r_idx;
    logic [RECORD_BITS-1:0] r_data;
    logic [HW_W-1:0]        r_hw, n_hw;
    logic                   r_free_vld, n_free_vld;
    logic [IDX_W-1:0]       r_free, n_free;
    logic                   r_cur_neg, n_cur_neg;
    logic [CUR_W-1:0]       r_cur, n_cur;
    logic [IDX_W-1:0]       r_walk, n_walk;
    logic [2:0]             r_status, n_status;
    logic                   r_res_vld, n_res_vld;
    logic [IDX_W-1:0]       r_res_idx, n_res_idx;
    logic [RECORD_BITS-1:0] r_res_data, n_res_data;

    // Slot memory: deleted flag on top of the record word
    logic [RECORD_BITS:0]   mem [SLOT_COUNT];
    logic [RECORD_BITS:0]   r_rd;
    logic                   mem_re, mem_we;
    logic [IDX_W-1:0]       mem_ra, mem_wa;
    logic [RECORD_BITS:0]   mem_wd;

    logic                   in_accept;
    logic                   out_free, out_load;
    rssfl_pkg::t_result     out_res;

    logic                   idx_neg, idx_in_range;
    logic [CUR_W-1:0]       idx_val;
    logic [CUR_W:0]         scan_next;
    logic                   scan_go;
    logic [HW_W-1:0]        walk_inc;
    logic                   walk_more;
    logic [RECORD_BITS-1:0] rd_word;
    logic                   rd_deleted, link_ok;
    logic [RECORD_BITS-1:0] free_link;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Index, cursor and scan-walk arithmetic used by the sequencer
    assign idx_neg      = r_idx[10];
    assign idx_val      = CUR_W'(r_idx[9:0]);
    assign idx_in_range = !idx_neg && (idx_val < CUR_W'(r_hw));
    assign scan_next    = r_cur_neg ? '0 : ({1'b0, r_cur} + (CUR_W + 1)'(1));
    assign scan_go      = scan_next < (CUR_W + 1)'(r_hw);
    assign walk_inc     = HW_W'(r_walk) + HW_W'(1);
    assign walk_more    = walk_inc < r_hw;

    // Free link decode from the read word; a bad link ends the list
    assign rd_word    = r_rd[RECORD_BITS-1:0];
    assign rd_deleted = r_rd[RECORD_BITS];
    assign link_ok    = !rd_word[RECORD_BITS-1] && (rd_word < RECORD_BITS'(r_hw));
    assign free_link  = r_free_vld ? RECORD_BITS'(r_free) : '1;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_hw       = r_hw;
        n_free_vld = r_free_vld;
        n_free     = r_free;
        n_cur_neg  = r_cur_neg;
        n_cur      = r_cur;
        n_walk     = r_walk;
        n_status   = r_status;
        n_res_vld  = r_res_vld;
        n_res_idx  = r_res_idx;
        n_res_data = r_res_data;
        mem_re     = 1'b0;
        mem_ra     = r_walk;
        mem_we     = 1'b0;
        mem_wa     = r_walk;
        mem_wd     = {1'b0, r_data};
        out_load   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_ISSUE;
                end
            end

            S_ISSUE: begin
                n_status   = rssfl_pkg::ST_OK;
                n_res_vld  = 1'b0;
                n_res_data = '0;
                n_state    = S_DONE;
                unique case (r_op)
                    rssfl_pkg::OP_ADD: begin
                        if (r_free_vld) begin
                            mem_re  = 1'b1;
                            mem_ra  = r_free;
                            n_walk  = r_free;
                            n_state = S_EVAL;
                        end else if (r_hw < HW_W'(SLOT_COUNT)) begin
                            mem_we     = 1'b1;
                            mem_wa     = IDX_W'(r_hw);
                            mem_wd     = {1'b0, r_data};
                            n_cur_neg  = 1'b0;
                            n_cur      = CUR_W'(r_hw);
                            n_hw       = r_hw + HW_W'(1);
                            n_free_vld = 1'b0;
                            n_res_vld  = 1'b1;
                            n_res_idx  = IDX_W'(r_hw);
                        end else begin
                            n_status = rssfl_pkg::ST_FULL;
                        end
                    end
                    rssfl_pkg::OP_DEL, rssfl_pkg::OP_READ: begin
                        if (idx_in_range) begin
                            n_cur_neg = 1'b0;
                            n_cur     = idx_val;
                            mem_re    = 1'b1;
                            mem_ra    = IDX_W'(r_idx[9:0]);
                            n_walk    = IDX_W'(r_idx[9:0]);
                            n_state   = S_EVAL;
                        end else begin
                            n_status = rssfl_pkg::ST_RANGE;
                        end
                    end
                    rssfl_pkg::OP_SCAN: begin
                        if (scan_go) begin
                            n_cur_neg = 1'b0;
                            n_cur     = CUR_W'(scan_next);
                            mem_re    = 1'b1;
                            mem_ra    = IDX_W'(scan_next);
                            n_walk    = IDX_W'(scan_next);
                            n_state   = S_EVAL;
                        end else begin
                            n_status = rssfl_pkg::ST_END;
                        end
                    end
                    rssfl_pkg::OP_SETCUR: begin
                        n_cur_neg = idx_neg;
                        n_cur     = idx_val;
                    end
                    default: begin
                        n_status = rssfl_pkg::ST_RANGE;
                    end
                endcase
            end

            S_EVAL: begin
                n_state = S_DONE;
                unique case (r_op)
                    rssfl_pkg::OP_ADD: begin
                        mem_we     = 1'b1;
                        mem_wa     = r_walk;
                        mem_wd     = {1'b0, r_data};
                        n_free_vld = link_ok;
                        n_free     = rd_word[IDX_W-1:0];
                        n_cur_neg  = 1'b0;
                        n_cur      = CUR_W'(r_walk);
                        n_res_vld  = 1'b1;
                        n_res_idx  = r_walk;
                    end
                    rssfl_pkg::OP_DEL: begin
                        if (rd_deleted) begin
                            n_status = rssfl_pkg::ST_DELETED;
                        end else begin
                            mem_we     = 1'b1;
                            mem_wa     = r_walk;
                            mem_wd     = {1'b1, free_link};
                            n_free_vld = 1'b1;
                            n_free     = r_walk;
                        end
                    end
                    rssfl_pkg::OP_READ: begin
                        if (rd_deleted) begin
                            n_status = rssfl_pkg::ST_DELETED;
                        end else begin
                            n_res_data = rd_word;
                        end
                    end
                    rssfl_pkg::OP_SCAN: begin
                        if (!rd_deleted) begin
                            n_res_vld  = 1'b1;
                            n_res_idx  = r_walk;
                            n_res_data = rd_word;
                        end else if (walk_more) begin
                            // Advance to the next slot and keep walking
                            mem_re  = 1'b1;
                            mem_ra  = IDX_W'(walk_inc);
                            n_walk  = IDX_W'(walk_inc);
                            n_cur   = CUR_W'(walk_inc);
                            n_state = S_EVAL;
                        end else begin
                            n_status = rssfl_pkg::ST_END;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hw       <= '0;
            r_free_vld <= 1'b0;
            r_cur_neg  <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_hw       <= n_hw;
            r_free_vld <= n_free_vld;
            r_cur_neg  <= n_cur_neg;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= s_axis_tuser;
            r_idx  <= s_axis_tdata[10:0];
            r_data <= s_axis_tdata[11 +: RECORD_BITS];
        end
        r_free     <= n_free;
        r_cur      <= n_cur;
        r_walk     <= n_walk;
        r_status   <= n_status;
        r_res_vld  <= n_res_vld;
        r_res_idx  <= n_res_idx;
        r_res_data <= n_res_data;
    end

    // Slot memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    // Pack the finished result
    always_comb begin
        out_res.status     = r_status;
        out_res.res_idx    = r_res_vld ? rssfl_pkg::IDX_FIELD_W'(r_res_idx) : '1;
        out_res.res_data   = rssfl_pkg::DATA_FIELD_W'(r_res_data);
        out_res.slots_used = rssfl_pkg::IDX_FIELD_W'(r_hw);
    end

    rssfl_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (out_res),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

    // An accepted transaction always enters the issue step next
    a_accept_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_ISSUE))
        else $error("accepted transaction did not reach issue");

    // The high-water mark never passes the store size
    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= HW_W'(SLOT_COUNT))
        else $error("high-water mark beyond store size");

    // A free-list head always points below the high-water mark
    a_free_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_vld |-> (HW_W'(r_free) < r_hw))
        else $error("free-list head not below high-water mark");

    // A scan only examines allocated slots
    a_walk_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EVAL) && (r_op == rssfl_pkg::OP_SCAN)) |-> (HW_W'(r_walk) < r_hw))
        else $error("scan walked past high-water mark");

    // A result is only loaded when the output register has room
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a waiting transaction");

endmodule
